FILE: src/emat_pkg.sv
`timescale 1ns / 1ps
// Package for the EMA trend and min/max tracker: beat types, per-channel state,
// register indexes, channel codes, trend codes and reset values. No dependencies.
package emat_pkg;

	localparam int KNOWN_CHANNELS = 3;
	localparam int DEFAULT_CHANNELS = 3;

	localparam int SAMPLE_W = 24;
	localparam int ALPHA_W = 17;
	localparam int BAND_W = 23;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 23;

	// Q1.16 weight of one.
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd6554;
	localparam logic [BAND_W-1:0] BAND_TEMP_RESET = 23'd256;
	localparam logic [BAND_W-1:0] BAND_PRES_RESET = 23'd256;
	localparam logic [BAND_W-1:0] BAND_HUMI_RESET = 23'd512;

	localparam logic [1:0] CH_TEMP = 2'd0;
	localparam logic [1:0] CH_PRES = 2'd1;
	localparam logic [1:0] CH_HUMI = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_TEMP = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_PRES = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_HUMI = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BAND_TEMP = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BAND_PRES = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_BAND_HUMI = 3'd5;

	typedef enum logic [1:0] {
		TREND_NONE = 2'd0,
		TREND_RISE = 2'd1,
		TREND_FALL = 2'd2
	} trend_t;

	typedef struct packed {
		logic [1:0]                 channel;
		logic signed [SAMPLE_W-1:0] sample;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]                 out_channel;
		logic [1:0]                 trend;
		logic signed [SAMPLE_W-1:0] smoothed;
		logic signed [SAMPLE_W-1:0] session_min;
		logic signed [SAMPLE_W-1:0] session_max;
	} out_beat_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] average;
		logic signed [SAMPLE_W-1:0] reference;
		logic signed [SAMPLE_W-1:0] lowest;
		logic signed [SAMPLE_W-1:0] highest;
	} chan_state_t;

endpackage

FILE: src/emat_update.sv
`timescale 1ns / 1ps
// Combinational update of one channel's state for one sample: min/max, EMA step
// and trend decision. Depends on emat_pkg.
module emat_update
	import emat_pkg::*;
(
	input  logic                      seen,
	input  chan_state_t               cur,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [ALPHA_W-1:0]        alpha,
	input  logic [BAND_W-1:0]         band,
	output chan_state_t               nxt,
	output trend_t                    trend
);

	logic [ALPHA_W-1:0]         alpha_c;
	logic signed [SAMPLE_W:0]   delta;
	logic signed [SAMPLE_W+18:0] prod;
	logic signed [SAMPLE_W:0]   step;
	logic signed [SAMPLE_W+1:0] sum;
	logic signed [SAMPLE_W-1:0] avg_new;
	logic signed [SAMPLE_W:0]   tdiff;
	logic signed [SAMPLE_W:0]   band_s;

	always_comb begin
		// Weights above one behave as one.
		alpha_c = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
		delta = {sample[SAMPLE_W-1], sample} - {cur.average[SAMPLE_W-1], cur.average};
		prod = delta * $signed({2'b00, alpha_c});
		// Arithmetic shift by 16 rounds toward minus infinity; the step never
		// exceeds the delta in magnitude, so 25 bits hold it.
		step = prod[SAMPLE_W+16:16];
		sum = {{1{cur.average[SAMPLE_W-1]}}, cur.average[SAMPLE_W-1], cur.average}
			+ {step[SAMPLE_W], step};
		avg_new = sum[SAMPLE_W-1:0];
		tdiff = {avg_new[SAMPLE_W-1], avg_new} - {cur.reference[SAMPLE_W-1], cur.reference};
		band_s = $signed({2'b00, band});

		nxt = cur;
		trend = TREND_NONE;
		if (!seen) begin
			nxt.average = sample;
			nxt.reference = sample;
			nxt.lowest = sample;
			nxt.highest = sample;
		end else begin
			if (sample < cur.lowest) begin
				nxt.lowest = sample;
			end
			if (sample > cur.highest) begin
				nxt.highest = sample;
			end
			nxt.average = avg_new;
			if (tdiff >= band_s) begin
				trend = TREND_RISE;
			end else if (tdiff <= -band_s) begin
				trend = TREND_FALL;
			end else begin
				nxt.reference = avg_new;
			end
		end
	end

endmodule

FILE: src/ema_trend_minmax_tracker.sv
`timescale 1ns / 1ps
// Top level of the EMA trend and min/max tracker: input register, per-channel
// state, configuration registers and result register. Depends on emat_pkg, emat_update.

// Each input beat carries a channel (0 temperature, 1 pressure, 2 humidity) and a
// signed sample in 1/256 units. The block keeps, per channel, the session minimum
// and maximum, an exponential moving average updated as avg + ((alpha*(x-avg)) >>> 16)
// and a reference value; it returns one result beat per sample with the average,
// the minimum, the maximum and a trend of none, rising or falling. The first sample
// of a channel seeds all of its state and reports no trend. A beat whose channel is
// at or beyond CHANNELS, or names no known sensor, is swallowed without a result and
// changes nothing. The block sustains one sample per clock cycle while the output is not
// stalled: a beat is held in an input register, the single 25 by 19 bit multiply and
// the compares that follow it are combinational, and the result lands in the output
// register when the beat moves on from the input register. The state of a channel is
// written back together with the result, so a sample directly following one on the
// same channel sees the updated values. A new beat is taken while a finished result
// still waits at the output. Configuration is by a plain write port (alphas at
// indexes 0 to 2, bands at 3 to 5) and is meant to be written only while the block
// is idle.
module ema_trend_minmax_tracker
	import emat_pkg::*;
#(
	parameter int CHANNELS = DEFAULT_CHANNELS
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_beat_t               in_data,

	output logic                   out_valid,
	input  logic                   out_stall,
	output out_beat_t              out_data,

	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// Channels that both exist in storage and have configuration registers.
	localparam int LIVE_CHANNELS = (CHANNELS < KNOWN_CHANNELS) ? CHANNELS : KNOWN_CHANNELS;

	logic [ALPHA_W-1:0] alpha_q [KNOWN_CHANNELS];
	logic [BAND_W-1:0]  band_q [KNOWN_CHANNELS];

	logic        seen_q [CHANNELS];
	chan_state_t state_q [CHANNELS];

	logic      valid_s1;
	in_beat_t  beat_s1;
	logic      out_valid_q;
	out_beat_t out_q;

	logic               ch_ok;
	logic               advance;
	logic               take_in;
	logic               cur_seen;
	chan_state_t        cur_state;
	chan_state_t        nxt_state;
	trend_t             nxt_trend;
	logic [ALPHA_W-1:0] cur_alpha;
	logic [BAND_W-1:0]  cur_band;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q[0] <= ALPHA_RESET;
			alpha_q[1] <= ALPHA_RESET;
			alpha_q[2] <= ALPHA_RESET;
			band_q[0] <= BAND_TEMP_RESET;
			band_q[1] <= BAND_PRES_RESET;
			band_q[2] <= BAND_HUMI_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ALPHA_TEMP: alpha_q[0] <= cfg_data[ALPHA_W-1:0];
				REG_ALPHA_PRES: alpha_q[1] <= cfg_data[ALPHA_W-1:0];
				REG_ALPHA_HUMI: alpha_q[2] <= cfg_data[ALPHA_W-1:0];
				REG_BAND_TEMP:  band_q[0] <= cfg_data[BAND_W-1:0];
				REG_BAND_PRES:  band_q[1] <= cfg_data[BAND_W-1:0];
				REG_BAND_HUMI:  band_q[2] <= cfg_data[BAND_W-1:0];
				default: ;
			endcase
		end
	end

	// A beat in the input register moves on when its result has room, or at once
	// when its channel is not served.
	always_comb begin
		ch_ok = (32'(beat_s1.channel) < LIVE_CHANNELS);
		advance = valid_s1 && (!ch_ok || !out_valid_q || !out_stall);
		in_stall = valid_s1 && !advance;
		take_in = in_valid && !in_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			beat_s1 <= in_data;
		end
	end

	// Pick the addressed channel's state and settings.
	always_comb begin
		cur_seen = 1'b0;
		cur_state = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (32'(beat_s1.channel) == i) begin
				cur_seen = seen_q[i];
				cur_state = state_q[i];
			end
		end
		case (beat_s1.channel)
			CH_TEMP: begin
				cur_alpha = alpha_q[0];
				cur_band = band_q[0];
			end
			CH_PRES: begin
				cur_alpha = alpha_q[1];
				cur_band = band_q[1];
			end
			CH_HUMI: begin
				cur_alpha = alpha_q[2];
				cur_band = band_q[2];
			end
			default: begin
				cur_alpha = ALPHA_RESET;
				cur_band = BAND_TEMP_RESET;
			end
		endcase
	end

	emat_update u_update (
		.seen   (cur_seen),
		.cur    (cur_state),
		.sample (beat_s1.sample),
		.alpha  (cur_alpha),
		.band   (cur_band),
		.nxt    (nxt_state),
		.trend  (nxt_trend)
	);

	// Channel state is written back as the result is registered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				seen_q[i] <= 1'b0;
				state_q[i] <= '0;
			end
		end else if (advance && ch_ok) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (32'(beat_s1.channel) == i) begin
					seen_q[i] <= 1'b1;
					state_q[i] <= nxt_state;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && ch_ok) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ch_ok) begin
			out_q.out_channel <= beat_s1.channel;
			out_q.trend <= nxt_trend;
			out_q.smoothed <= nxt_state.average;
			out_q.session_min <= nxt_state.lowest;
			out_q.session_max <= nxt_state.highest;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// The input side is only held back while a beat waits in the input register.
	assert property (@(posedge clk) disable iff (!arst_n) in_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	// Results only ever come from served channels.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(out_data.out_channel) < LIVE_CHANNELS))
		else $error("result for a channel that is not served");

	// The average always lies between the session minimum and maximum.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.session_min <= out_data.smoothed)
			&& (out_data.smoothed <= out_data.session_max))
		else $error("average outside the session range");

	// Only the three trend codes appear.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.trend == TREND_NONE) || (out_data.trend == TREND_RISE)
			|| (out_data.trend == TREND_FALL))
		else $error("trend code without meaning");

	// A beat of a served channel that moves on shows up as a result at the next edge.
	assert property (@(posedge clk) disable iff (!arst_n) (advance && ch_ok) |=> out_valid)
		else $error("result lost on the way to the output register");

endmodule
